// ===== rtl/core/tsss_pkg.sv =====
// Shared types and codes for the timed servo step sequencer.
// No dependencies; every other file but tsss_ram imports it.
package tsss_pkg;

    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_WRITE_HDR = 3'd1;
    localparam logic [2:0] ACT_WRITE_TGT = 3'd2;
    localparam logic [2:0] ACT_START     = 3'd3;
    localparam logic [2:0] ACT_CANCEL    = 3'd4;

    localparam logic CFG_MOTOR_PRESENT = 1'b0;
    localparam logic CFG_TICKS_PER_MS  = 1'b1;

    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [15:0] TICKS_PER_MS_RESET = 16'd1000;

    typedef enum logic [1:0] {
        RS_IDLE = 2'd0,
        RS_RUN  = 2'd1,
        RS_DONE = 2'd2,
        RS_ERR  = 2'd3
    } run_t;

    typedef enum logic [1:0] {
        FS_ACCEPT,
        FS_HDR,
        FS_SCAN,
        FS_CMD
    } fsm_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  cmd_motor;
        logic [15:0] cmd_angle;
        run_t        seq_state;
        logic [4:0]  step_now;
        logic        accepted;
        logic        last;
    } res_t;

endpackage

// ===== rtl/core/timed_servo_step_sequencer.sv =====
// Top level of the timed servo step sequencer: stream ports, engine and result buffer.
// Depends on tsss_pkg, tsss_engine and tsss_out_fifo.
//
// Tick, table write, cancel and refused words stream at one word per clock while the
// result buffer is not full. A word that applies a step (an accepted start, or a tick
// whose wait has run out and that does not end the run) reads the step header memory;
// then for each masked motor a scan state reads its target from the target memory, which
// has one read port, and a command state sends it; a closing scan state sends the status
// word (an error status at the first absent motor). Results leave through a two-word
// buffer, so input is taken while one result still waits downstream.
// Table memories are not cleared at reset and hold nothing until written.
module timed_servo_step_sequencer import tsss_pkg::*; #(
    parameter int MAX_STEPS   = 16,
    parameter int MOTOR_COUNT = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // step_slot, motor, angle, wait_ms, drive_mask, count
    input  logic [2:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cmd_motor, cmd_angle, seq_state, step_now, accepted
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    logic fifo_full;
    logic push;
    res_t push_word;
    res_t m_word;

    tsss_engine #(.MAX_STEPS(MAX_STEPS), .MOTOR_COUNT(MOTOR_COUNT)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_slot   (s_tdata[3:0]),
        .in_motor  (s_tdata[6:4]),
        .in_angle  (s_tdata[22:7]),
        .in_wait   (s_tdata[38:23]),
        .in_mask   (s_tdata[43:39]),
        .in_count  (s_tdata[48:44]),
        .fifo_full (fifo_full),
        .push      (push),
        .push_word (push_word)
    );

    tsss_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .full      (fifo_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_word    (m_word)
    );

    assign m_tdata = {5'd0, m_word.accepted, m_word.step_now, m_word.seq_state,
                      m_word.cmd_angle, m_word.cmd_motor};
    assign m_tuser = m_word.kind;
    assign m_tlast = m_word.last;

endmodule

// ===== rtl/core/tsss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tsss_out_fifo.sv =====
// Two-word result buffer between the sequencer engine and the result stream.
// Depends on tsss_pkg for the result word type.
module tsss_out_fifo import tsss_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_word,
    output logic full,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_word
);

    res_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_word  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/core/tsss_engine.sv =====
// Sequencer engine: step table memories, run control, prescaler and command scan.
// Depends on tsss_pkg and tsss_ram; feeds tsss_out_fifo.
module tsss_engine import tsss_pkg::*; #(
    parameter int MAX_STEPS   = 16,
    parameter int MOTOR_COUNT = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  in_action,
    input  logic [3:0]  in_slot,
    input  logic [2:0]  in_motor,
    input  logic [15:0] in_angle,
    input  logic [15:0] in_wait,
    input  logic [4:0]  in_mask,
    input  logic [4:0]  in_count,
    input  logic        fifo_full,
    output logic        push,
    output res_t        push_word
);

    localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int TD = MAX_STEPS * MOTOR_COUNT;
    localparam int TW = (TD > 1) ? $clog2(TD) : 1;
    localparam logic [4:0] MOTOR_SEL =
        (MOTOR_COUNT >= 5) ? 5'h1f : 5'((1 << MOTOR_COUNT) - 1);

    fsm_t        fsm_reg, fsm_next;
    run_t        run_state_reg, run_state_next;
    logic [4:0]  step_index_reg, step_index_next;
    logic [4:0]  run_count_reg, run_count_next;
    logic [15:0] sub_ms_reg, sub_ms_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] cur_wait_reg, cur_wait_next;
    logic [4:0]  mask_rem_reg, mask_rem_next;
    logic [2:0]  motor_reg, motor_next;
    logic        err_acc_reg, err_acc_next;
    logic [4:0]  present_reg;
    logic [15:0] tpm_reg;

    logic        accept;
    logic        running;
    logic        slot_ok;
    logic        motor_ok;
    logic        start_ok;
    logic [15:0] tpm_eff;
    logic [15:0] sub_inc;
    logic        ms_wrap;
    logic [15:0] sub_tick;
    logic [15:0] el_tick;
    logic        step_due;
    logic [4:0]  idx_inc;
    logic        run_end;
    logic        apply_go;
    logic [2:0]  low_m;
    logic        low_present;

    logic          hdr_we, hdr_re;
    logic [IW-1:0] hdr_waddr, hdr_raddr;
    logic [20:0]   hdr_rdata;
    logic          tgt_we, tgt_re;
    logic [TW-1:0] tgt_waddr, tgt_raddr;
    logic [15:0]   tgt_rdata;

    tsss_ram #(.WIDTH(21), .DEPTH(MAX_STEPS)) u_hdr_ram (
        .aclk  (aclk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata ({in_wait, in_mask}),
        .re    (hdr_re),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    tsss_ram #(.WIDTH(16), .DEPTH(TD)) u_tgt_ram (
        .aclk  (aclk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (in_angle),
        .re    (tgt_re),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    assign in_ready = (fsm_reg == FS_ACCEPT) && !fifo_full;
    assign accept   = in_valid && in_ready;
    assign running  = (run_state_reg == RS_RUN);

    // decode the incoming word and the prescaler step
    always_comb begin
        slot_ok  = ({3'b000, in_slot} < 7'(MAX_STEPS));
        motor_ok = ({1'b0, in_motor} < 4'(MOTOR_COUNT));
        start_ok = !running && (in_count != 5'd0) && ({2'b00, in_count} <= 7'(MAX_STEPS));
        tpm_eff  = (tpm_reg == 16'd0) ? 16'd1 : tpm_reg;
        sub_inc  = sub_ms_reg + 16'd1;
        ms_wrap  = (sub_inc >= tpm_eff);
        sub_tick = ms_wrap ? 16'd0 : sub_inc;
        el_tick  = (ms_wrap && elapsed_reg != 16'hffff) ? elapsed_reg + 16'd1 : elapsed_reg;
        step_due = (el_tick >= cur_wait_reg);
        idx_inc  = step_index_reg + 5'd1;
        run_end  = (idx_inc >= run_count_reg);
        apply_go = 1'b0;
        if (in_action == ACT_TICK) begin
            apply_go = running && step_due && !run_end;
        end else if (in_action == ACT_START) begin
            apply_go = start_ok;
        end
        low_m = 3'd0;
        for (int m = 4; m >= 0; m--) begin
            if (mask_rem_reg[m]) begin
                low_m = 3'(m);
            end
        end
        low_present = present_reg[low_m];
    end

    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FS_ACCEPT: begin
                if (accept && apply_go) begin
                    fsm_next = FS_HDR;
                end
            end
            FS_HDR: begin
                fsm_next = FS_SCAN;
            end
            FS_SCAN: begin
                if (mask_rem_reg == 5'd0 || !low_present) begin
                    if (!fifo_full) begin
                        fsm_next = FS_ACCEPT;
                    end
                end else begin
                    fsm_next = FS_CMD;
                end
            end
            FS_CMD: begin
                if (!fifo_full) begin
                    fsm_next = FS_SCAN;
                end
            end
            default: fsm_next = FS_ACCEPT;
        endcase
    end

    always_comb begin
        run_state_next  = run_state_reg;
        step_index_next = step_index_reg;
        run_count_next  = run_count_reg;
        sub_ms_next     = sub_ms_reg;
        elapsed_next    = elapsed_reg;
        cur_wait_next   = cur_wait_reg;
        mask_rem_next   = mask_rem_reg;
        motor_next      = motor_reg;
        err_acc_next    = err_acc_reg;
        hdr_we    = 1'b0;
        hdr_re    = 1'b0;
        hdr_waddr = IW'(in_slot);
        hdr_raddr = (in_action == ACT_START) ? '0 : IW'(idx_inc);
        tgt_we    = 1'b0;
        tgt_re    = 1'b0;
        tgt_waddr = TW'(32'(in_slot) * 32'(MOTOR_COUNT) + 32'(in_motor));
        tgt_raddr = TW'(32'(step_index_reg) * 32'(MOTOR_COUNT) + 32'(low_m));
        push      = 1'b0;
        push_word = '{kind: KIND_STATUS, cmd_motor: 3'd0, cmd_angle: 16'd0,
                      seq_state: run_state_reg, step_now: step_index_reg,
                      accepted: 1'b0, last: 1'b1};
        unique case (fsm_reg)
            FS_ACCEPT: begin
                if (accept) begin
                    case (in_action)
                        ACT_TICK: begin
                            if (running) begin
                                push_word.accepted = 1'b1;
                                sub_ms_next  = sub_tick;
                                elapsed_next = el_tick;
                                if (step_due) begin
                                    step_index_next = idx_inc;
                                    if (run_end) begin
                                        run_state_next = RS_DONE;
                                    end else begin
                                        hdr_re       = 1'b1;
                                        err_acc_next = 1'b1;
                                    end
                                end
                            end
                        end
                        ACT_WRITE_HDR: begin
                            if (!running && slot_ok) begin
                                hdr_we             = 1'b1;
                                push_word.accepted = 1'b1;
                            end
                        end
                        ACT_WRITE_TGT: begin
                            if (!running && slot_ok && motor_ok) begin
                                tgt_we             = 1'b1;
                                push_word.accepted = 1'b1;
                            end
                        end
                        ACT_START: begin
                            if (start_ok) begin
                                run_count_next  = in_count;
                                step_index_next = 5'd0;
                                run_state_next  = RS_RUN;
                                hdr_re          = 1'b1;
                                err_acc_next    = 1'b0;
                            end
                        end
                        ACT_CANCEL: begin
                            run_state_next     = RS_IDLE;
                            step_index_next    = 5'd0;
                            run_count_next     = 5'd0;
                            sub_ms_next        = 16'd0;
                            elapsed_next       = 16'd0;
                            push_word.accepted = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    push               = !apply_go;
                    push_word.seq_state = run_state_next;
                    push_word.step_now  = step_index_next;
                end
            end
            FS_HDR: begin
                mask_rem_next = hdr_rdata[4:0] & MOTOR_SEL;
                cur_wait_next = hdr_rdata[20:5];
            end
            FS_SCAN: begin
                if (mask_rem_reg == 5'd0) begin
                    if (!fifo_full) begin
                        sub_ms_next        = 16'd0;
                        elapsed_next       = 16'd0;
                        push               = 1'b1;
                        push_word.accepted = 1'b1;
                    end
                end else if (!low_present) begin
                    if (!fifo_full) begin
                        run_state_next      = RS_ERR;
                        push                = 1'b1;
                        push_word.seq_state = RS_ERR;
                        push_word.accepted  = err_acc_reg;
                    end
                end else begin
                    tgt_re        = 1'b1;
                    motor_next    = low_m;
                    mask_rem_next = mask_rem_reg & ~(5'd1 << low_m);
                end
            end
            FS_CMD: begin
                if (!fifo_full) begin
                    push      = 1'b1;
                    push_word = '{kind: KIND_CMD, cmd_motor: motor_reg, cmd_angle: tgt_rdata,
                                  seq_state: run_state_reg, step_now: step_index_reg,
                                  accepted: 1'b1, last: 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= FS_ACCEPT;
            run_state_reg  <= RS_IDLE;
            step_index_reg <= 5'd0;
            run_count_reg  <= 5'd0;
            sub_ms_reg     <= 16'd0;
            elapsed_reg    <= 16'd0;
            present_reg    <= 5'd0;
            tpm_reg        <= TICKS_PER_MS_RESET;
        end else begin
            fsm_reg        <= fsm_next;
            run_state_reg  <= run_state_next;
            step_index_reg <= step_index_next;
            run_count_reg  <= run_count_next;
            sub_ms_reg     <= sub_ms_next;
            elapsed_reg    <= elapsed_next;
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MOTOR_PRESENT) begin
                    present_reg <= cfg_wdata[4:0];
                end else begin
                    tpm_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_wait_reg <= cur_wait_next;
        mask_rem_reg <= mask_rem_next;
        motor_reg    <= motor_next;
        err_acc_reg  <= err_acc_next;
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_full |-> !push)
        else $error("result pushed into a full buffer");

    a_hdr_read_then_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_re |=> (fsm_reg == FS_HDR))
        else $error("header read not followed by header stage");

    a_index_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_state_reg == RS_RUN) |-> (step_index_reg < run_count_reg))
        else $error("step index reached run count while running");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_word.last) |=> (fsm_reg == FS_ACCEPT))
        else $error("closing status did not return to accept");

endmodule

// ===== sim/tsss_checker.sv =====
// Result checker for the timed servo step sequencer: tracks config and input words,
// predicts the result words and compares them with the result channel.
// Depends on tsss_pkg.
`timescale 1ns / 1ps

module tsss_checker import tsss_pkg::*; #(
    parameter int MAX_STEPS   = 16,
    parameter int MOTOR_COUNT = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);

    logic [4:0]  present_mask;
    logic [15:0] tick_div;
    logic [4:0]  slot_mask [MAX_STEPS];
    logic [15:0] slot_hold [MAX_STEPS];
    logic [15:0] slot_angle [MAX_STEPS * MOTOR_COUNT];
    run_t        seq_state_q;
    logic [4:0]  cur_step;
    logic [4:0]  steps_total;
    logic [15:0] tick_phase;
    logic [15:0] ms_elapsed;
    res_t        pending_results [$];

    function automatic void push_result(input logic kind, input logic [2:0] mot,
                                        input logic [15:0] ang, input logic acc,
                                        input logic lst);
        res_t r;
        r.kind      = kind;
        r.cmd_motor = mot;
        r.cmd_angle = ang;
        r.seq_state = seq_state_q;
        r.step_now  = cur_step;
        r.accepted  = acc;
        r.last      = lst;
        pending_results.push_back(r);
    endfunction

    // Send one command per masked motor; stop at the first absent motor.
    function automatic bit emit_step();
        int base;
        if (cur_step >= MAX_STEPS) begin
            seq_state_q = RS_ERR;
            return 1'b0;
        end
        base = cur_step * MOTOR_COUNT;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            if (slot_mask[cur_step][m]) begin
                if (!present_mask[m]) begin
                    seq_state_q = RS_ERR;
                    return 1'b0;
                end
                push_result(KIND_CMD, 3'(m), slot_angle[base + m], 1'b1, 1'b0);
            end
        end
        tick_phase = '0;
        ms_elapsed = '0;
        return 1'b1;
    endfunction

    function automatic void advance_sequencer(input logic [2:0] act, input logic [55:0] d);
        logic [3:0]  slot;
        logic [2:0]  mot;
        logic [15:0] ang;
        logic [15:0] hold;
        logic [15:0] limit;
        logic [4:0]  mask;
        logic [4:0]  cnt;
        logic        acc;
        bit          running;
        slot    = d[3:0];
        mot     = d[6:4];
        ang     = d[22:7];
        hold    = d[38:23];
        mask    = d[43:39];
        cnt     = d[48:44];
        acc     = 1'b0;
        running = (seq_state_q == RS_RUN);
        case (act)
            ACT_TICK: begin
                if (running) begin
                    limit = (tick_div == 16'd0) ? 16'd1 : tick_div;
                    hold  = (cur_step < MAX_STEPS) ? slot_hold[cur_step] : 16'd0;
                    acc   = 1'b1;
                    tick_phase = tick_phase + 16'd1;
                    if (tick_phase >= limit) begin
                        tick_phase = '0;
                        if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 16'd1;
                    end
                    if (ms_elapsed >= hold) begin
                        cur_step = cur_step + 5'd1;
                        if (cur_step >= steps_total) seq_state_q = RS_DONE;
                        else void'(emit_step());
                    end
                end
            end
            ACT_WRITE_HDR: begin
                if (!running && slot < MAX_STEPS) begin
                    slot_mask[slot] = mask;
                    slot_hold[slot] = hold;
                    acc = 1'b1;
                end
            end
            ACT_WRITE_TGT: begin
                if (!running && slot < MAX_STEPS && mot < MOTOR_COUNT) begin
                    slot_angle[slot * MOTOR_COUNT + mot] = ang;
                    acc = 1'b1;
                end
            end
            ACT_START: begin
                if (!running && cnt != 5'd0 && cnt <= MAX_STEPS) begin
                    steps_total = cnt;
                    cur_step    = '0;
                    seq_state_q = RS_RUN;
                    acc = emit_step();
                end
            end
            ACT_CANCEL: begin
                seq_state_q = RS_IDLE;
                cur_step    = '0;
                steps_total = '0;
                tick_phase  = '0;
                ms_elapsed  = '0;
                acc = 1'b1;
            end
            default: ;
        endcase
        push_result(KIND_STATUS, 3'd0, 16'd0, acc, 1'b1);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        res_t want;
        if (pending_results.size() == 0) begin
            $error("result word with nothing expected: tdata %h tuser %b tlast %b",
                   m_tdata, m_tuser, m_tlast);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(m_tuser));
            check_field("cmd_motor", 16'(want.cmd_motor), 16'(m_tdata[2:0]));
            check_field("cmd_angle", want.cmd_angle, m_tdata[18:3]);
            check_field("seq_state", 16'(want.seq_state), 16'(m_tdata[20:19]));
            check_field("step_now", 16'(want.step_now), 16'(m_tdata[25:21]));
            check_field("accepted", 16'(want.accepted), 16'(m_tdata[26]));
            check_field("last", 16'(want.last), 16'(m_tlast));
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            present_mask = '0;
            tick_div     = TICKS_PER_MS_RESET;
            seq_state_q  = RS_IDLE;
            cur_step     = '0;
            steps_total  = '0;
            tick_phase   = '0;
            ms_elapsed   = '0;
            mismatches   = 0;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MOTOR_PRESENT) present_mask = cfg_wdata[4:0];
                else tick_div = cfg_wdata;
            end
            if (s_tvalid && s_tready) advance_sequencer(s_tuser, s_tdata);
            if (m_tvalid && m_tready) check_result();
        end
        pending = pending_results.size();
    end

endmodule

// ===== sim/timed_servo_step_sequencer_tb.sv =====
// Testbench top for the timed servo step sequencer: clock, reset, stimulus and verdict.
// Depends on tsss_pkg, timed_servo_step_sequencer and tsss_checker.
`timescale 1ns / 1ps

module timed_servo_step_sequencer_tb;
    import tsss_pkg::*;

    localparam int MAX_STEPS     = 16;
    localparam int MOTOR_COUNT   = 5;
    localparam int RANDOM_WORDS  = 120;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [2:0]  motor;
        logic [15:0] angle;
        logic [15:0] hold_ms;
        logic [4:0]  mask;
        logic [4:0]  count;
    } cmd_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // step_slot, motor, angle, wait_ms, drive_mask, count
    logic [2:0]  s_tuser   = '0;   // action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // cmd_motor, cmd_angle, seq_state, step_now, accepted
    logic        m_tuser;          // kind
    logic        m_tlast;

    int          mismatches;
    int          pending;
    int          cycle_count  = 0;
    int          rx_stall     = 0;
    bit          src_idle     = 1'b1;
    bit          snk_idle     = 1'b1;
    int          random_words = 0;
    int          tick_scale   = 1000;
    logic [4:0]  mask_union [MAX_STEPS];
    bit          tgt_known [MAX_STEPS * MOTOR_COUNT];

    always #1 aclk = ~aclk;

    timed_servo_step_sequencer #(
        .MAX_STEPS   (MAX_STEPS),
        .MOTOR_COUNT (MOTOR_COUNT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    tsss_checker #(
        .MAX_STEPS   (MAX_STEPS),
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) rx_stall = snk_idle ? $urandom_range(0, 3) : 0;
        else if (!m_tready && rx_stall > 0) rx_stall = rx_stall - 1;
    end

    always @(negedge aclk) m_tready <= aresetn && (rx_stall == 0);

    function automatic cmd_word_t random_word(input logic [2:0] act);
        cmd_word_t w;
        w.action  = act;
        w.slot    = 4'($urandom);
        w.motor   = 3'($urandom);
        w.angle   = 16'($urandom);
        w.hold_ms = 16'($urandom);
        w.mask    = 5'($urandom);
        w.count   = 5'($urandom);
        return w;
    endfunction

    task automatic send_word(input cmd_word_t w);
        int gap;
        gap = src_idle ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= w.action;
        s_tdata  <= {7'd0, w.count, w.mask, w.hold_ms, w.angle, w.motor, w.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_action(input logic [2:0] act);
        send_word(random_word(act));
    endtask

    task automatic send_start(input logic [4:0] n);
        cmd_word_t w;
        w = random_word(ACT_START);
        w.count = n;
        send_word(w);
    endtask

    task automatic put_header(input int slot, input logic [4:0] mask, input logic [15:0] hold);
        cmd_word_t w;
        w = random_word(ACT_WRITE_HDR);
        w.slot    = 4'(slot);
        w.mask    = mask;
        w.hold_ms = hold;
        mask_union[slot] |= mask;
        send_word(w);
    endtask

    task automatic put_target(input int slot, input int motor, input logic [15:0] ang);
        cmd_word_t w;
        w = random_word(ACT_WRITE_TGT);
        w.slot  = 4'(slot);
        w.motor = 3'(motor);
        w.angle = ang;
        if (motor < MOTOR_COUNT) tgt_known[slot * MOTOR_COUNT + motor] = 1'b1;
        send_word(w);
    endtask

    // Starts are kept refusable so that no step with unwritten entries is ever applied.
    task automatic send_noise();
        cmd_word_t w;
        w = random_word(3'($urandom_range(0, 7)));
        if (w.action == ACT_START)
            w.count = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
        if (w.action == ACT_WRITE_HDR) mask_union[w.slot] |= w.mask;
        send_word(w);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_config(input logic [4:0] present, input logic [15:0] scale);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MOTOR_PRESENT;
        cfg_wdata <= {11'd0, present};
        @(negedge aclk);
        cfg_index <= CFG_TICKS_PER_MS;
        cfg_wdata <= scale;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tick_scale = (scale == 16'd0) ? 1 : scale;
    endtask

    // Cancel, load steps 0..n-1, start and send up to 40 ticks, with noise mixed in.
    task automatic run_program();
        int          n;
        int          ticks;
        longint      planned;
        logic [4:0]  mask;
        logic [15:0] hold;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, MAX_STEPS) : $urandom_range(1, 3);
        planned = 0;
        send_action(ACT_CANCEL);
        random_words++;
        for (int s = 0; s < n; s++) begin
            mask = 5'($urandom);
            hold = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            put_header(s, mask, hold);
            random_words++;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                if (mask_union[s][m] && (!tgt_known[s * MOTOR_COUNT + m] || $urandom_range(0, 1))) begin
                    put_target(s, m, 16'($urandom_range(0, 36000)));
                    random_words++;
                end
            end
            planned += (hold == 16'd0) ? 1 : longint'(hold) * tick_scale;
            if (planned > 1000) planned = 1000;
        end
        if ($urandom_range(0, 3) == 0) drain();
        send_start(5'(n));
        random_words++;
        ticks = int'(planned) + $urandom_range(0, 3);
        if (ticks > 40) ticks = 40;
        repeat (ticks) begin
            if ($urandom_range(0, 5) == 0) send_noise();
            send_action(ACT_TICK);
            random_words++;
        end
    endtask

    initial begin
        int phase;
        for (int s = 0; s < MAX_STEPS; s++) mask_union[s] = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        send_action(ACT_TICK);
        send_start(5'd0);
        send_start(5'd17);
        send_start(5'd31);
        send_action(ACT_CANCEL);
        send_action(3'd5);
        send_action(3'd7);

        write_config(5'h1F, 16'd1);
        put_header(0, 5'h1F, 16'd0);
        put_header(1, 5'b10001, 16'd1);
        put_header(15, 5'h1F, 16'hFFFF);
        put_target(0, 0, 16'd0);
        put_target(0, 1, 16'd36000);
        put_target(0, 2, 16'hFFFF);
        put_target(0, 3, 16'd1);
        put_target(0, 4, 16'd18000);
        put_target(1, 0, 16'd12345);
        put_target(1, 4, 16'd36000);
        put_target(15, 5, 16'd100);
        put_target(3, 7, 16'd200);
        send_start(5'd2);
        send_action(ACT_WRITE_HDR);
        send_action(ACT_WRITE_TGT);
        send_start(5'd1);
        send_action(ACT_TICK);
        send_action(ACT_TICK);
        send_action(ACT_TICK);

        write_config(5'b00011, 16'd1);
        send_start(5'd1);
        send_action(ACT_TICK);
        send_action(ACT_CANCEL);

        phase = -1;
        while (random_words < RANDOM_WORDS) begin
            if (random_words / 24 != phase && random_words / 24 < 5) begin
                phase    = random_words / 24;
                src_idle = (phase != 2);
                snk_idle = (phase != 1);
                case (phase)
                    0:       write_config(5'h1F, 16'd1);
                    1:       write_config(5'($urandom), 16'd2);
                    2:       write_config(5'h00, 16'd0);
                    3:       write_config(5'($urandom), 16'd3);
                    default: write_config(5'h1F, 16'hFFFF);
                endcase
            end
            run_program();
        end

        drain();
        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
